// File: rtl/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types, codes and defaults for the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int CAPACITY_DEF     = 16;
  localparam int ELEMENT_BITS_DEF = 32;

  localparam int OP_W    = 3;
  localparam int INDEX_W = 4;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int ELEM_W  = 32;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_GET    = 3'd1;
  localparam logic [OP_W-1:0] OP_SET    = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd4;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  localparam logic [31:0] MASK_RESET = 32'hFFFF_FFFF;

  typedef struct packed {
    logic exec;       // execute a non-scan transaction now
    logic scan_start; // latch key, clear pointer
    logic scan_step;  // advance pointer
    logic scan_load;  // load search result
    logic scanning;   // read port follows the pointer
  } ile_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_hit;
    logic scan_last;
  } ile_stat_t;

endpackage

// File: rtl/ile_req_if.sv
// ----------------------------------------------------------------------------
// ile_req_if
// Request channel: valid/ready with operation, index and value.
// ----------------------------------------------------------------------------
interface ile_req_if;
  logic                         valid;
  logic                         ready;
  logic [ile_pkg::OP_W-1:0]     operation;
  logic [ile_pkg::INDEX_W-1:0]  index;
  logic [ile_pkg::VALUE_W-1:0]  value;
  modport source (output valid, operation, index, value, input ready);
  modport sink   (input valid, operation, index, value, output ready);
endinterface

// File: rtl/ile_rsp_if.sv
// ----------------------------------------------------------------------------
// ile_rsp_if
// Result channel: valid/ready with status, element, position and count.
// ----------------------------------------------------------------------------
interface ile_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ile_pkg::STAT_W-1:0]   status;
  logic [ile_pkg::ELEM_W-1:0]   element;
  logic [ile_pkg::POS_W-1:0]    position;
  logic [ile_pkg::COUNT_W-1:0]  count;
  modport source (output valid, status, element, position, count, input ready);
  modport sink   (input valid, status, element, position, count, output ready);
endinterface

// File: rtl/ile_ctrl.sv
// ----------------------------------------------------------------------------
// ile_ctrl
// Sequencer: accepts transactions, runs the search scan, owns result valid.
// ----------------------------------------------------------------------------
module ile_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ile_pkg::ile_stat_t st,
  output ile_pkg::ile_cmd_t  cmd
);
  import ile_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free, accept, scan_done;

  always_comb begin
    out_free       = !out_valid_r || out_ready;
    in_ready       = (state_r == S_IDLE) && out_free;
    accept         = in_ready && in_valid;
    scan_done      = (state_r == S_SCAN) && (st.scan_hit || st.scan_last);
    cmd.exec       = accept && !st.need_scan;
    cmd.scan_start = accept && st.need_scan;
    cmd.scan_step  = (state_r == S_SCAN) && !scan_done;
    cmd.scan_load  = scan_done && out_free;
    cmd.scanning   = (state_r == S_SCAN);

    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (cmd.scan_start) state_nxt = S_SCAN;
      S_SCAN: if (cmd.scan_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.exec || cmd.scan_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

// File: rtl/ile_dp.sv
// ----------------------------------------------------------------------------
// ile_dp
// Datapath: element cells, count, compare mask, scan pointer, result regs.
// ----------------------------------------------------------------------------
module ile_dp #(
  parameter int CAPACITY     = ile_pkg::CAPACITY_DEF,
  parameter int ELEMENT_BITS = ile_pkg::ELEMENT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [31:0]                   cfg_wdata,
  input  logic [ile_pkg::OP_W-1:0]      req_op,
  input  logic [ile_pkg::INDEX_W-1:0]   req_index,
  input  logic [ile_pkg::VALUE_W-1:0]   req_value,
  input  ile_pkg::ile_cmd_t             cmd,
  output ile_pkg::ile_stat_t            st,
  output logic [ile_pkg::STAT_W-1:0]    rsp_status,
  output logic [ile_pkg::ELEM_W-1:0]    rsp_element,
  output logic [ile_pkg::POS_W-1:0]     rsp_position,
  output logic [ile_pkg::COUNT_W-1:0]   rsp_count
);
  import ile_pkg::*;

  localparam int EB   = ELEMENT_BITS;
  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;
  localparam logic [CMPW-1:0] CAP = CMPW'(CAPACITY);

  logic [EB-1:0]   ent_r [CAPACITY];
  logic [EB-1:0]   ent_nxt [CAPACITY];
  logic [CMPW-1:0] cnt_r, cnt_nxt;
  logic [31:0]     mask_r;
  logic [EB-1:0]   key_r;
  logic [AW-1:0]   ptr_r;

  logic [STAT_W-1:0]  status_r, status_nxt;
  logic [ELEM_W-1:0]  element_r, element_nxt;
  logic [POS_W-1:0]   position_r, position_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic [CMPW-1:0] idx_w, ptr_w;
  logic [EB-1:0]   val_w, rd_data;
  logic [63:0]     rd_wide, cmp_wide;
  logic [AW-1:0]   rd_addr;
  logic            idx_ok, not_full;
  logic            do_app, do_set, do_rem, do_ins;

  always_comb begin
    idx_w    = CMPW'(req_index);
    ptr_w    = CMPW'(ptr_r);
    val_w    = EB'(req_value);
    idx_ok   = idx_w < cnt_r;
    not_full = cnt_r < CAP;
    rd_addr  = cmd.scanning ? ptr_r : idx_w[AW-1:0];
    rd_data  = ent_r[rd_addr];
    rd_wide  = 64'(rd_data);
    cmp_wide = 64'(rd_data ^ key_r) & 64'(mask_r);

    st.need_scan = (req_op == OP_SEARCH) && (cnt_r != '0);
    st.scan_hit  = (cmp_wide == 64'd0);
    st.scan_last = (ptr_w + CMPW'(1)) >= cnt_r;

    do_app = 1'b0;
    do_set = 1'b0;
    do_rem = 1'b0;
    do_ins = 1'b0;
    cnt_nxt      = cnt_r;
    status_nxt   = status_r;
    element_nxt  = element_r;
    position_nxt = position_r;

    if (cmd.exec) begin
      status_nxt   = ST_MISS;
      element_nxt  = '0;
      position_nxt = '0;
      case (req_op)
        OP_APPEND: begin
          if (not_full) begin
            status_nxt = ST_OK;
            do_app     = 1'b1;
            cnt_nxt    = cnt_r + CMPW'(1);
          end else begin
            status_nxt = ST_FULL;
          end
        end
        OP_GET: begin
          if (idx_ok) begin
            status_nxt  = ST_OK;
            element_nxt = rd_wide[ELEM_W-1:0];
          end
        end
        OP_SET: begin
          if (idx_ok) begin
            status_nxt = ST_OK;
            do_set     = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (idx_ok) begin
            status_nxt  = ST_OK;
            element_nxt = rd_wide[ELEM_W-1:0];
            do_rem      = 1'b1;
            cnt_nxt     = cnt_r - CMPW'(1);
          end
        end
        OP_INSERT: begin
          if ((cnt_r == '0 && idx_w == '0) || (idx_ok && not_full)) begin
            status_nxt = ST_OK;
            do_ins     = 1'b1;
            cnt_nxt    = cnt_r + CMPW'(1);
          end else if (idx_ok) begin
            status_nxt = ST_FULL;
          end
        end
        default: status_nxt = ST_MISS;
      endcase
    end else if (cmd.scan_load) begin
      status_nxt   = st.scan_hit ? ST_OK : ST_MISS;
      element_nxt  = '0;
      position_nxt = st.scan_hit ? ptr_w[POS_W-1:0] : '0;
    end
    count_nxt = cnt_nxt[COUNT_W-1:0];

    for (int i = 0; i < CAPACITY; i++) begin
      ent_nxt[i] = ent_r[i];
      if (do_app && CMPW'(i) == cnt_r) ent_nxt[i] = val_w;
      if (do_set && CMPW'(i) == idx_w) ent_nxt[i] = val_w;
      if (do_rem && CMPW'(i) >= idx_w && i < CAPACITY - 1) ent_nxt[i] = ent_r[(i + 1) % CAPACITY];
      if (do_ins && CMPW'(i) > idx_w) ent_nxt[i] = ent_r[(i + CAPACITY - 1) % CAPACITY];
      if (do_ins && CMPW'(i) == idx_w) ent_nxt[i] = val_w;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
    status_r   <= status_nxt;
    element_r  <= element_nxt;
    position_r <= position_nxt;
    count_r    <= count_nxt;
    if (cmd.scan_start) begin
      key_r <= val_w;
      ptr_r <= '0;
    end else if (cmd.scan_step) begin
      ptr_r <= ptr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      mask_r <= MASK_RESET;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_we) mask_r <= cfg_wdata;
    end
  end

  assign rsp_status   = status_r;
  assign rsp_element  = element_r;
  assign rsp_position = position_r;
  assign rsp_count    = count_r;
endmodule

// File: rtl/indexed_list_engine.sv
// Append/get/set/remove/insert results are registered and valid in the cycle after acceptance.
// Search scans one element per cycle from position 0 until the first match or the last element;
// an empty list is not scanned and answers like the other operations.
// Throughput: one transaction at a time; the next is accepted once the result is taken,
// or in the same cycle; a stalled result holds off the input.
// Reset (rst_n low, synchronous) empties the list and sets compare_mask to all ones.
// ----------------------------------------------------------------------------
// indexed_list_engine
// Bounded ordered list with append, get, set, remove, insert and search.
// ----------------------------------------------------------------------------
module indexed_list_engine #(
  parameter int CAPACITY     = ile_pkg::CAPACITY_DEF,
  parameter int ELEMENT_BITS = ile_pkg::ELEMENT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ile_req_if.sink     in_if,
  ile_rsp_if.source   out_if,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import ile_pkg::*;

  ile_cmd_t  cmd;
  ile_stat_t st;
  logic      in_ready, out_valid;

  ile_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_if.ready),
    .st        (st),
    .cmd       (cmd)
  );

  ile_dp #(
    .CAPACITY     (CAPACITY),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .req_op       (in_if.operation),
    .req_index    (in_if.index),
    .req_value    (in_if.value),
    .cmd          (cmd),
    .st           (st),
    .rsp_status   (out_if.status),
    .rsp_element  (out_if.element),
    .rsp_position (out_if.position),
    .rsp_count    (out_if.count)
  );

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;
endmodule

// File: rtl/ile_checker.sv
// ----------------------------------------------------------------------------
// ile_checker
// Port-level checks for the indexed list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ile_checker #(
  parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_element,
  input logic [3:0]  out_position,
  input logic [4:0]  out_count
);
  import ile_pkg::*;

  localparam logic [5:0] CAP_LIM = (CAPACITY > 31) ? 6'd31 : 6'(CAPACITY);

  a_no_valid_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_MISS || out_status == ST_FULL))
    else $error("bad status");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_element == '0 && out_position == '0)
    else $error("error result carries data");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && CAPACITY < 32 |-> {1'b0, out_count} <= CAP_LIM)
    else $error("count above capacity");
endmodule

bind indexed_list_engine ile_checker #(.CAPACITY(CAPACITY)) u_ile_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_status   (out_if.status),
  .out_element  (out_if.element),
  .out_position (out_if.position),
  .out_count    (out_if.count)
);
